// File: sv/acb64_pkg.sv
// Shared types, constants and functions of the address record encoder.
`default_nettype none
package acb64_pkg;

   // CRC-16/XMODEM generator polynomial.
   localparam logic [15:0] CRC_POLY = 16'h1021;

   // Tag byte values and the testnet flag.
   localparam logic [7:0] TAG_BOUNCE    = 8'h11;
   localparam logic [7:0] TAG_NONBOUNCE = 8'h51;
   localparam logic [7:0] TAG_TESTNET   = 8'h80;

   // Workchain byte values.
   localparam logic [7:0] CHAIN_BASE  = 8'h00;
   localparam logic [7:0] CHAIN_OTHER = 8'hff;

   // Position of the last hash byte of an address.
   localparam logic [4:0] HASH_LAST = 5'd31;

   // Configuration register indexes.
   localparam logic [1:0] CSR_BOUNCEABLE   = 2'd0;
   localparam logic [1:0] CSR_TESTNET_ONLY = 2'd1;
   localparam logic [1:0] CSR_OTHER_CHAIN  = 2'd2;

   // Place of a hash byte inside a group of three hash bytes.
   typedef enum logic [1:0] {
      PHASE_FIRST  = 2'd0,
      PHASE_SECOND = 2'd1,
      PHASE_THIRD  = 2'd2
   } phase_type;

   // Four characters of one base64 group.
   typedef struct packed {
      logic [6:0] char_a;
      logic [6:0] char_b;
      logic [6:0] char_c;
      logic [6:0] char_d;
   } chars_type;

   // One byte of CRC-16/XMODEM, MSB first, eight unrolled bit steps.
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

   // Standard base64 alphabet as ASCII.
   function automatic logic [6:0] b64_char(input logic [5:0] v);
      logic [6:0] w;
      logic [6:0] c;
      w = {1'b0, v};
      if (v < 6'd26) begin
         c = w + 7'h41;
      end else if (v < 6'd52) begin
         c = w + 7'h47;
      end else if (v < 6'd62) begin
         c = w - 7'd4;
      end else if (v == 6'd62) begin
         c = 7'h2b;
      end else begin
         c = 7'h2f;
      end
      return c;
   endfunction

endpackage
`default_nettype wire

// File: sv/acb64_if.sv
// Valid/ready channel interfaces for hash bytes and base64 groups.
`default_nettype none
interface acb64_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] hash_byte;

   modport source (output valid, output hash_byte, input ready);
   modport sink   (input valid, input hash_byte, output ready);
endinterface

interface acb64_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] char_a;
   logic [6:0] char_b;
   logic [6:0] char_c;
   logic [6:0] char_d;
   logic       final_group;

   modport source (output valid, output char_a, output char_b, output char_c,
                   output char_d, output final_group, input ready);
   modport sink   (input valid, input char_a, input char_b, input char_c,
                   input char_d, input final_group, output ready);
endinterface
`default_nettype wire

// File: sv/acb64_group_enc.sv
// Maps one 3-byte record group to its four base64 characters.
`default_nettype none
module acb64_group_enc
   import acb64_pkg::*;
(
   input  wire logic [23:0] group_word,
   output chars_type        group_chars
);

   // Split into four sextets, most significant first.
   always_comb begin
      group_chars.char_a = b64_char(group_word[23:18]);
      group_chars.char_b = b64_char(group_word[17:12]);
      group_chars.char_c = b64_char(group_word[11:6]);
      group_chars.char_d = b64_char(group_word[5:0]);
   end

endmodule
`default_nettype wire

// File: sv/address_crc16_base64_encoder_top.sv
// Top level of the address record encoder: framing, CRC-16 and base64 output.
//
// Usage: feed the 32 bytes of an account hash, first byte first, one beat per
// byte on req_chan. The block frames them with a tag byte and a workchain byte
// taken from the csr_ registers, appends a big-endian CRC-16/XMODEM over the
// first 34 record bytes, and returns the 36-byte record as base64 on rsp_chan:
// one beat of four characters per 3-byte group, twelve beats per address, the
// last one flagged by final_group. Hash bytes that do not close a group give
// no beat.
// Throughput is one hash byte per cycle while the receiver keeps up. A byte
// is held in an input register, then one pass of logic (one unrolled CRC byte
// step and the base64 table) fills the result register, from which the beat is
// presented on rsp_chan. The tag, workchain byte and their CRC seed are
// re-registered from the csr_ registers each cycle, so configuration must be
// written while idle; the block itself does not enforce it.
// When the receiver stalls, a full result register blocks only bytes that
// close a group; other bytes keep flowing until one needs the output.
// Synchronous reset clears the byte position, CRC, open group and both valid
// flags, and loads the register defaults (bounceable set, others clear).
`default_nettype none
module address_crc16_base64_encoder_top
   import acb64_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   acb64_req_if.sink       req_chan,
   acb64_rsp_if.source     rsp_chan,
   input  wire logic       csr_write_enable,
   input  wire logic [1:0] csr_index,
   input  wire logic       csr_write_data
);

   // Configuration registers.
   logic bounceable_ff;
   logic testnet_only_ff;
   logic other_chain_ff;

   // Derived framing bytes and the CRC after tag and workchain.
   logic [7:0]  tag_ff;
   logic [7:0]  chain_ff;
   logic [15:0] seed_ff;
   logic [7:0]  tag_in;
   logic [7:0]  chain_in;

   // Input register.
   logic       s1_valid_ff;
   logic [7:0] s1_byte_ff;
   logic       s1_adv;

   // Record state.
   logic [4:0]  pos_ff;
   logic [4:0]  pos_in;
   logic [15:0] crc_ff;
   logic [15:0] crc_in;
   logic [15:0] pend_ff;
   logic [15:0] pend_in;
   phase_type   phase_ff;
   phase_type   phase_in;

   // Group logic.
   logic        is_first;
   logic        is_last;
   logic        closes;
   logic [15:0] crc_new;
   logic [23:0] group_word;
   chars_type   group_chars;

   // Result register.
   logic      out_valid_ff;
   chars_type out_chars_ff;
   logic      out_final_ff;

   // Configuration writes; unknown indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         bounceable_ff   <= 1'b1;
         testnet_only_ff <= 1'b0;
         other_chain_ff  <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_BOUNCEABLE:   bounceable_ff   <= csr_write_data;
            CSR_TESTNET_ONLY: testnet_only_ff <= csr_write_data;
            CSR_OTHER_CHAIN:  other_chain_ff  <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Framing bytes and CRC seed follow the registers in the next cycle.
   always_comb begin
      tag_in   = (bounceable_ff ? TAG_BOUNCE : TAG_NONBOUNCE)
                 | (testnet_only_ff ? TAG_TESTNET : 8'h00);
      chain_in = other_chain_ff ? CHAIN_OTHER : CHAIN_BASE;
   end

   always_ff @(posedge clock) begin
      tag_ff   <= tag_in;
      chain_ff <= chain_in;
      seed_ff  <= crc_byte(crc_byte(16'h0000, tag_in), chain_in);
   end

   // Group decode and the single CRC byte step.
   always_comb begin
      is_first = (pos_ff == 5'd0);
      is_last  = (pos_ff == HASH_LAST);
      closes   = is_first || is_last || (phase_ff == PHASE_THIRD);
      crc_new  = crc_byte(is_first ? seed_ff : crc_ff, s1_byte_ff);
      priority if (is_first) begin
         group_word = {tag_ff, chain_ff, s1_byte_ff};
      end else if (is_last) begin
         group_word = {s1_byte_ff, crc_new};
      end else begin
         group_word = {pend_ff, s1_byte_ff};
      end
   end

   acb64_group_enc u_group_enc (
      .group_word  (group_word),
      .group_chars (group_chars)
   );

   // A byte moves on unless it closes a group and the result register is stuck.
   assign s1_adv       = s1_valid_ff && (!closes || !out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || s1_adv;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         s1_valid_ff <= req_chan.valid;
      end
      if (req_chan.ready && req_chan.valid) begin
         s1_byte_ff <= req_chan.hash_byte;
      end
   end

   // Next record state.
   always_comb begin
      pos_in   = pos_ff + 5'd1;
      crc_in   = crc_new;
      pend_in  = 16'h0000;
      phase_in = PHASE_FIRST;
      priority if (is_last) begin
         pos_in = 5'd0;
         crc_in = 16'h0000;
      end else if (!is_first) begin
         unique case (phase_ff)
            PHASE_FIRST: begin
               pend_in  = {s1_byte_ff, 8'h00};
               phase_in = PHASE_SECOND;
            end
            PHASE_SECOND: begin
               pend_in  = {pend_ff[15:8], s1_byte_ff};
               phase_in = PHASE_THIRD;
            end
            default: begin
               pend_in  = 16'h0000;
               phase_in = PHASE_FIRST;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= 5'd0;
         crc_ff   <= 16'h0000;
         pend_ff  <= 16'h0000;
         phase_ff <= PHASE_FIRST;
      end else if (s1_adv) begin
         pos_ff   <= pos_in;
         crc_ff   <= crc_in;
         pend_ff  <= pend_in;
         phase_ff <= phase_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s1_adv && closes) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
      if (s1_adv && closes) begin
         out_chars_ff <= group_chars;
         out_final_ff <= is_last;
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.char_a      = out_chars_ff.char_a;
   assign rsp_chan.char_b      = out_chars_ff.char_b;
   assign rsp_chan.char_c      = out_chars_ff.char_c;
   assign rsp_chan.char_d      = out_chars_ff.char_d;
   assign rsp_chan.final_group = out_final_ff;

endmodule
`default_nettype wire
